### src/arm_ik_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and tables of the planar arm solver
package arm_ik_pkg;

  localparam int POS_FRAC_BITS   = 6;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int ANG_SHIFT       = 16 - ANGLE_FRAC_BITS;

  localparam int CORDIC_STEPS = 18;
  localparam int DIV_STEPS    = 31;
  localparam int SQRT_STEPS   = 31;
  localparam int CNT_W        = 5;

  // cordic x/y width, angle width in 1/65536 degree, final angle math width
  localparam int VW = 52;
  localparam int ZW = 26;
  localparam int TW = 29;

  localparam logic signed [VW-1:0] CORDIC_GAIN = VW'(652032874);
  localparam logic signed [ZW-1:0] DEG90  = ZW'(90 * 65536);
  localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * 65536);
  localparam logic signed [ZW-1:0] DEG360 = ZW'(360 * 65536);
  localparam logic signed [VW-1:0] NORM_LIM = {{(VW-41){1'b0}}, 1'b1, 40'b0};

  localparam logic signed [16:0] Z_MAX = 17'sh0FFFF;
  localparam logic signed [16:0] Z_MIN = 17'sh10000;

  typedef enum logic [2:0] {
    REG_UPPER     = 3'd0,
    REG_FORE      = 3'd1,
    REG_HAND      = 3'd2,
    REG_X_START   = 3'd3,
    REG_X_STOP    = 3'd4,
    REG_Z_OFFSET  = 3'd5,
    REG_HIT_PITCH = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [15:0]        l1;
    logic [15:0]        l2;
    logic [15:0]        l3;
    logic [15:0]        x_start;
    logic [15:0]        x_stop;
    logic signed [16:0] z_offset;
    logic signed [16:0] hit_pitch;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    l1: 16'd14311, l2: 16'd9715, l3: 16'd6613, x_start: 16'd20480,
    x_stop: 16'd7680, z_offset: 17'sd2560, hit_pitch: 17'sd15360
  };

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_ROT_INIT,
    OP_ROT_STEP,
    OP_ROT_END,
    OP_MUL_L3C,
    OP_MUL_L3S,
    OP_MUL_X2,
    OP_MUL_Z2,
    OP_MUL_L1,
    OP_MUL_L2,
    OP_MUL_L12,
    OP_DEN,
    OP_NEXT_X,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_MUL_CC,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_SQRT_END,
    OP_MUL_L2S,
    OP_MUL_L2C,
    OP_XA,
    OP_VEC_INIT,
    OP_VEC_NORM,
    OP_VEC_STEP,
    OP_VEC_END,
    OP_WRITE_OK,
    OP_WRITE_FAIL
  } op_t;

  typedef enum logic [1:0] {
    VSRC_SC,
    VSRC_ZX,
    VSRC_AB
  } vsel_t;

  typedef struct packed {
    op_t              op;
    logic [CNT_W-1:0] step;
    vsel_t            vsel;
  } cmd_t;

  typedef struct packed {
    logic search;
    logic x_more;
    logic unreach;
    logic norm_done;
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_ROT,
    S_ROT_END,
    S_MUL_L3C,
    S_MUL_L3S,
    S_MUL_X2,
    S_MUL_Z2,
    S_MUL_L1,
    S_MUL_L2,
    S_MUL_L12,
    S_DEN,
    S_REACH,
    S_DIV,
    S_DIV_END,
    S_MUL_CC,
    S_SQRT_INIT,
    S_SQRT,
    S_SQRT_END,
    S_MUL_L2S,
    S_MUL_L2C,
    S_XA,
    S_VEC_INIT,
    S_VEC_NORM,
    S_VEC,
    S_VEC_END,
    S_OK,
    S_FAIL
  } state_t;

  // arctangent of 2^-i in 1/65536 degree
  function automatic logic signed [ZW-1:0] atan_entry(input logic [CNT_W-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = ZW'(2949120);
      5'd1:    v = ZW'(1740967);
      5'd2:    v = ZW'(919879);
      5'd3:    v = ZW'(466945);
      5'd4:    v = ZW'(234379);
      5'd5:    v = ZW'(117304);
      5'd6:    v = ZW'(58666);
      5'd7:    v = ZW'(29335);
      5'd8:    v = ZW'(14668);
      5'd9:    v = ZW'(7334);
      5'd10:   v = ZW'(3667);
      5'd11:   v = ZW'(1833);
      5'd12:   v = ZW'(917);
      5'd13:   v = ZW'(458);
      5'd14:   v = ZW'(229);
      5'd15:   v = ZW'(115);
      5'd16:   v = ZW'(57);
      5'd17:   v = ZW'(29);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### src/arm_ik_dp.sv
`timescale 1ns / 1ps
// solver datapath: shared multiplier, cordic, divider, square root and result register
module arm_ik_dp (
  input  logic                     clk,
  input  arm_ik_pkg::cmd_t         cmd,
  input  arm_ik_pkg::cfg_t         cfg,
  input  logic                     action,
  input  logic signed [16:0]       target_x,
  input  logic signed [16:0]       target_z,
  input  logic signed [16:0]       target_pitch,
  output arm_ik_pkg::status_t      status,
  output logic                     reachable,
  output logic signed [16:0]       x_used,
  output logic signed [18:0]       shoulder_angle,
  output logic [16:0]              elbow_angle,
  output logic signed [18:0]       wrist_angle
);
  import arm_ik_pkg::*;

  localparam logic signed [65:0] HALF30   = 66'sd536870912;
  localparam logic signed [TW-1:0] ANG_HALF = TW'(2 ** (ANG_SHIFT - 1));
  localparam logic [61:0] SQ_ONE = 62'h1000_0000_0000_0000;

  logic                    mode;
  logic signed [17:0]      xc;
  logic signed [16:0]      zc;
  logic signed [ZW-1:0]    pa;
  logic signed [VW-1:0]    vx, vy;
  logic signed [ZW-1:0]    vz;
  logic                    vneg, vzero;
  logic signed [31:0]      cp, sp;
  logic signed [65:0]      prod;
  logic signed [19:0]      x2, z2;
  logic signed [40:0]      acc;
  logic [33:0]             den;
  logic [34:0]             rem;
  logic [DIV_STEPS-1:0]    quo;
  logic signed [31:0]      c;
  logic [61:0]             sv, sr, sb;
  logic [30:0]             s_root;
  logic signed [VW-1:0]    ya, xa;
  logic signed [ZW-1:0]    t2, ta, tb;

  logic signed [17:0]      z_sum;
  logic signed [16:0]      z_hit;
  logic signed [16:0]      pitch_sel;
  logic signed [ZW-1:0]    fold_a, rot_a;
  logic                    rot_neg;
  logic signed [VW-1:0]    x_sh, y_sh, vy_abs, vec_xi, vec_yi;
  logic signed [ZW-1:0]    tab;
  logic                    ccw;
  logic signed [32:0]      ma, mb;
  logic signed [65:0]      prod_rnd;
  logic signed [40:0]      den_s, acc_mag;
  logic                    rem_ge;
  logic [34:0]             rem_sub;
  logic [61:0]             sq_try;
  logic                    sq_ge;
  logic signed [TW-1:0]    t1, t3, q1, q3, q4;

  // search height saturates to the field range
  always_comb begin
    z_sum = 18'(target_z) + 18'(cfg.z_offset);
    if (z_sum[17] != z_sum[16]) begin
      z_hit = z_sum[17] ? Z_MIN : Z_MAX;
    end else begin
      z_hit = z_sum[16:0];
    end
    pitch_sel = action ? cfg.hit_pitch : target_pitch;
  end

  // fold the pitch into [-90, 90] degrees for the rotation
  always_comb begin
    fold_a = pa;
    if (pa > DEG180) begin
      fold_a = pa - DEG360;
    end else if (pa < -DEG180) begin
      fold_a = pa + DEG360;
    end
    rot_a   = fold_a;
    rot_neg = 1'b0;
    if (fold_a > DEG90) begin
      rot_a   = fold_a - DEG180;
      rot_neg = 1'b1;
    end else if (fold_a < -DEG90) begin
      rot_a   = fold_a + DEG180;
      rot_neg = 1'b1;
    end
  end

  // cordic micro-rotation, shared by rotation and vectoring
  always_comb begin
    x_sh   = vx >>> cmd.step;
    y_sh   = vy >>> cmd.step;
    tab    = atan_entry(cmd.step);
    ccw    = (cmd.op == OP_ROT_STEP) ? !vz[ZW-1] : vy[VW-1];
    vy_abs = vy[VW-1] ? -vy : vy;
    case (cmd.vsel)
      VSRC_SC: begin
        vec_xi = VW'(c);
        vec_yi = VW'(s_root);
      end
      VSRC_ZX: begin
        vec_xi = VW'(x2);
        vec_yi = VW'(z2);
      end
      VSRC_AB: begin
        vec_xi = xa;
        vec_yi = ya;
      end
      default: begin
        vec_xi = '0;
        vec_yi = '0;
      end
    endcase
  end

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_MUL_L3C: begin ma = 33'(cfg.l3); mb = 33'(cp); end
      OP_MUL_L3S: begin ma = 33'(cfg.l3); mb = 33'(sp); end
      OP_MUL_X2:  begin ma = 33'(x2);     mb = 33'(x2); end
      OP_MUL_Z2:  begin ma = 33'(z2);     mb = 33'(z2); end
      OP_MUL_L1:  begin ma = 33'(cfg.l1); mb = 33'(cfg.l1); end
      OP_MUL_L2:  begin ma = 33'(cfg.l2); mb = 33'(cfg.l2); end
      OP_MUL_L12: begin ma = 33'(cfg.l1); mb = 33'(cfg.l2); end
      OP_MUL_CC:  begin ma = 33'(c);      mb = 33'(c); end
      OP_MUL_L2S: begin ma = 33'(cfg.l2); mb = 33'(s_root); end
      OP_MUL_L2C: begin ma = 33'(cfg.l2); mb = 33'(c); end
      default: ;
    endcase
  end

  always_comb begin
    prod_rnd = (prod + HALF30) >>> 30;
    den_s    = $signed(41'(den));
    acc_mag  = acc[40] ? -acc : acc;
    rem_ge   = rem >= 35'(den);
    rem_sub  = rem_ge ? rem - 35'(den) : rem;
    sq_try   = sr + sb;
    sq_ge    = sv >= sq_try;
    t1       = TW'(ta) - TW'(tb);
    t3       = TW'(pa) - t1 - TW'(t2);
    q1       = (TW'(DEG180) + t1 + ANG_HALF) >>> ANG_SHIFT;
    q3       = (TW'(DEG180) + TW'(t2) + ANG_HALF) >>> ANG_SHIFT;
    q4       = (TW'(DEG180) + t3 + ANG_HALF) >>> ANG_SHIFT;
  end

  always_comb begin
    status.search    = mode;
    status.x_more    = xc > $signed({2'b00, cfg.x_stop});
    status.unreach   = (den == '0) || (acc > den_s) || (acc < -den_s);
    status.norm_done = vzero || (vx >= NORM_LIM) || (vy_abs >= NORM_LIM);
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    case (cmd.op)
      OP_LOAD: begin
        mode <= action;
        xc   <= action ? $signed({2'b00, cfg.x_start}) : 18'(target_x);
        zc   <= action ? z_hit : target_z;
        pa   <= ZW'(pitch_sel) <<< ANG_SHIFT;
      end
      OP_ROT_INIT: begin
        vx   <= CORDIC_GAIN;
        vy   <= '0;
        vz   <= rot_a;
        vneg <= rot_neg;
      end
      OP_ROT_STEP, OP_VEC_STEP: begin
        if (!(cmd.op == OP_VEC_STEP && vzero)) begin
          if (ccw) begin
            vx <= vx - y_sh;
            vy <= vy + x_sh;
            vz <= vz - tab;
          end else begin
            vx <= vx + y_sh;
            vy <= vy - x_sh;
            vz <= vz + tab;
          end
        end
      end
      OP_ROT_END: begin
        cp <= vneg ? -32'(vx) : 32'(vx);
        sp <= vneg ? -32'(vy) : 32'(vy);
      end
      OP_MUL_L3S: x2 <= 20'(xc) - 20'(prod_rnd);
      OP_MUL_X2:  z2 <= 20'(zc) - 20'(prod_rnd);
      OP_MUL_Z2:  acc <= 41'(prod);
      OP_MUL_L1:  acc <= acc + 41'(prod);
      OP_MUL_L2,
      OP_MUL_L12: acc <= acc - 41'(prod);
      OP_DEN:     den <= 34'(prod) << 1;
      OP_NEXT_X:  xc <= xc - (18'sd1 <<< POS_FRAC_BITS);
      OP_DIV_INIT: begin
        rem <= 35'(acc_mag);
        quo <= '0;
      end
      OP_DIV_STEP: begin
        rem <= rem_sub << 1;
        quo <= {quo[DIV_STEPS-2:0], rem_ge};
      end
      OP_DIV_END: c <= acc[40] ? -$signed(32'(quo)) : $signed(32'(quo));
      OP_SQRT_INIT: begin
        sv <= SQ_ONE - 62'(prod);
        sr <= '0;
        sb <= SQ_ONE;
      end
      OP_SQRT_STEP: begin
        if (sq_ge) begin
          sv <= sv - sq_try;
          sr <= (sr >> 1) + sb;
        end else begin
          sr <= sr >> 1;
        end
        sb <= sb >> 2;
      end
      OP_SQRT_END: s_root <= sr[30:0];
      OP_MUL_L2C:  ya <= VW'(prod);
      OP_XA:       xa <= (VW'(cfg.l1) <<< 30) + VW'(prod);
      OP_VEC_INIT: begin
        vzero <= (vec_xi == '0) && (vec_yi == '0);
        if (vec_xi[VW-1]) begin
          vz <= vec_yi[VW-1] ? -DEG180 : DEG180;
          vx <= -vec_xi;
          vy <= -vec_yi;
        end else begin
          vz <= '0;
          vx <= vec_xi;
          vy <= vec_yi;
        end
      end
      OP_VEC_NORM: begin
        if (!status.norm_done) begin
          vx <= vx <<< 1;
          vy <= vy <<< 1;
        end
      end
      OP_VEC_END: begin
        case (cmd.vsel)
          VSRC_SC: t2 <= vz;
          VSRC_ZX: ta <= vz;
          default: tb <= vz;
        endcase
      end
      OP_WRITE_OK: begin
        reachable      <= 1'b1;
        x_used         <= xc[16:0];
        shoulder_angle <= q1[18:0];
        elbow_angle    <= q3[16:0];
        wrist_angle    <= q4[18:0];
      end
      OP_WRITE_FAIL: begin
        reachable      <= 1'b0;
        x_used         <= mode ? '0 : xc[16:0];
        shoulder_angle <= '0;
        elbow_angle    <= '0;
        wrist_angle    <= '0;
      end
      default: ;
    endcase
  end

endmodule

### src/arm_ik_ctrl.sv
`timescale 1ns / 1ps
// solver sequencer: steps the datapath through one item and owns the result handshake
module arm_ik_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  arm_ik_pkg::status_t status,
  output arm_ik_pkg::cmd_t    cmd
);
  import arm_ik_pkg::*;

  localparam logic [CNT_W-1:0] LAST_CORDIC = CNT_W'(CORDIC_STEPS - 1);
  localparam logic [CNT_W-1:0] LAST_DIV    = CNT_W'(DIV_STEPS - 1);
  localparam logic [CNT_W-1:0] LAST_SQRT   = CNT_W'(SQRT_STEPS - 1);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  vsel_t            vidx, vidx_next;
  logic             out_valid_next;
  logic             slot_free, write;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      vidx      <= VSRC_SC;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      vidx      <= vidx_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    vidx_next  = vidx;
    cmd        = '0;
    cmd.op     = OP_IDLE;
    cmd.step   = cnt;
    cmd.vsel   = vidx;
    in_ready   = (state == S_IDLE);
    slot_free  = !out_valid || out_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.search && !status.x_more) begin
          state_next = S_FAIL;
        end else begin
          cmd.op     = OP_ROT_INIT;
          cnt_next   = '0;
          state_next = S_ROT;
        end
      end
      S_ROT: begin
        cmd.op = OP_ROT_STEP;
        if (cnt == LAST_CORDIC) begin
          state_next = S_ROT_END;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_ROT_END: begin
        cmd.op     = OP_ROT_END;
        state_next = S_MUL_L3C;
      end
      S_MUL_L3C: begin cmd.op = OP_MUL_L3C; state_next = S_MUL_L3S; end
      S_MUL_L3S: begin cmd.op = OP_MUL_L3S; state_next = S_MUL_X2; end
      S_MUL_X2:  begin cmd.op = OP_MUL_X2;  state_next = S_MUL_Z2; end
      S_MUL_Z2:  begin cmd.op = OP_MUL_Z2;  state_next = S_MUL_L1; end
      S_MUL_L1:  begin cmd.op = OP_MUL_L1;  state_next = S_MUL_L2; end
      S_MUL_L2:  begin cmd.op = OP_MUL_L2;  state_next = S_MUL_L12; end
      S_MUL_L12: begin cmd.op = OP_MUL_L12; state_next = S_DEN; end
      S_DEN:     begin cmd.op = OP_DEN;     state_next = S_REACH; end
      S_REACH: begin
        if (status.unreach) begin
          if (status.search) begin
            cmd.op     = OP_NEXT_X;
            state_next = S_CHECK;
          end else begin
            state_next = S_FAIL;
          end
        end else begin
          cmd.op     = OP_DIV_INIT;
          cnt_next   = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (cnt == LAST_DIV) begin
          state_next = S_DIV_END;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DIV_END: begin cmd.op = OP_DIV_END; state_next = S_MUL_CC; end
      S_MUL_CC:  begin cmd.op = OP_MUL_CC;  state_next = S_SQRT_INIT; end
      S_SQRT_INIT: begin
        cmd.op     = OP_SQRT_INIT;
        cnt_next   = '0;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT_STEP;
        if (cnt == LAST_SQRT) begin
          state_next = S_SQRT_END;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_SQRT_END: begin cmd.op = OP_SQRT_END; state_next = S_MUL_L2S; end
      S_MUL_L2S:  begin cmd.op = OP_MUL_L2S;  state_next = S_MUL_L2C; end
      S_MUL_L2C:  begin cmd.op = OP_MUL_L2C;  state_next = S_XA; end
      S_XA: begin
        cmd.op     = OP_XA;
        vidx_next  = VSRC_SC;
        state_next = S_VEC_INIT;
      end
      S_VEC_INIT: begin
        cmd.op     = OP_VEC_INIT;
        state_next = S_VEC_NORM;
      end
      S_VEC_NORM: begin
        cmd.op = OP_VEC_NORM;
        if (status.norm_done) begin
          cnt_next   = '0;
          state_next = S_VEC;
        end
      end
      S_VEC: begin
        cmd.op = OP_VEC_STEP;
        if (cnt == LAST_CORDIC) begin
          state_next = S_VEC_END;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_VEC_END: begin
        cmd.op = OP_VEC_END;
        case (vidx)
          VSRC_SC: begin vidx_next = VSRC_ZX; state_next = S_VEC_INIT; end
          VSRC_ZX: begin vidx_next = VSRC_AB; state_next = S_VEC_INIT; end
          default: state_next = S_OK;
        endcase
      end
      S_OK: begin
        if (slot_free) begin
          cmd.op     = OP_WRITE_OK;
          state_next = S_IDLE;
        end
      end
      S_FAIL: begin
        if (slot_free) begin
          cmd.op     = OP_WRITE_FAIL;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    write          = (cmd.op == OP_WRITE_OK) || (cmd.op == OP_WRITE_FAIL);
    out_valid_next = write ? 1'b1 : (out_ready ? 1'b0 : out_valid);
  end

`ifndef SYNTHESIS
  a_write_slot_free: assert property (@(posedge clk) disable iff (rst)
    write |-> (!out_valid || out_ready))
    else $error("result written over an untaken beat");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != S_IDLE))
    else $error("accepted beat did not start work");
  a_write_shows_valid: assert property (@(posedge clk) disable iff (rst)
    write |=> out_valid)
    else $error("written result not presented");
  a_cordic_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROT || state == S_VEC) |-> (cnt <= LAST_CORDIC))
    else $error("cordic step index out of range");
`endif

endmodule

### src/planar_arm_inverse_kinematics.sv
`timescale 1ns / 1ps
// Planar three-link arm inverse kinematics, top level. Positions are in 1/64 mm and angles
// in 1/256 degree. Action 0 solves once for target_x, target_z and target_pitch; action 1
// tries x from search_x_start down in 1 mm steps, at z plus hit_z_offset (saturated) and
// hit_pitch, and returns the first reachable x above search_x_stop. Angles are reported as
// 180 degrees plus the joint angle; yaw_angle is always zero. When no solution exists
// reachable is low, all angles are zero and x_used is target_x (direct) or zero (search).
// One item is worked at a time by a single shared datapath: input beats are taken only
// while the sequencer is idle, while the finished result sits in its own output register
// until taken. Each try runs the 18-step cordic for the pitch, seven multiplier steps and
// the reach check; a solved try goes on through a bit-serial divider, a bit-serial root
// and three 18-step cordic arctangents, each preceded by up to 40 one-bit normalizing
// shifts. An item is loaded, runs its tries and has its result written; a search makes
// at most (search_x_start - search_x_stop + 63) / 64 tries. Configuration registers are
// written through cfg_we / cfg_index / cfg_data; the user must do so only while idle,
// which the block itself does not enforce; indexes beyond the list are ignored.
module planar_arm_inverse_kinematics (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic signed [16:0] target_x,
  input  logic signed [16:0] target_z,
  input  logic signed [16:0] target_pitch,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               reachable,
  output logic signed [16:0] x_used,
  output logic signed [18:0] shoulder_angle,
  output logic               yaw_angle,
  output logic [16:0]        elbow_angle,
  output logic signed [18:0] wrist_angle
);
  import arm_ik_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // configuration registers, write only
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_UPPER:     cfg.l1        <= cfg_data[15:0];
        REG_FORE:      cfg.l2        <= cfg_data[15:0];
        REG_HAND:      cfg.l3        <= cfg_data[15:0];
        REG_X_START:   cfg.x_start   <= cfg_data[15:0];
        REG_X_STOP:    cfg.x_stop    <= cfg_data[15:0];
        REG_Z_OFFSET:  cfg.z_offset  <= $signed(cfg_data);
        REG_HIT_PITCH: cfg.hit_pitch <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // sequencer: one state per datapath step, loop counters for the iterative units
  arm_ik_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath holds the operands of the current item and the result register
  arm_ik_dp u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .cfg            (cfg),
    .action         (action),
    .target_x       (target_x),
    .target_z       (target_z),
    .target_pitch   (target_pitch),
    .status         (status),
    .reachable      (reachable),
    .x_used         (x_used),
    .shoulder_angle (shoulder_angle),
    .elbow_angle    (elbow_angle),
    .wrist_angle    (wrist_angle)
  );

  // planar arm: yaw never moves
  assign yaw_angle = 1'b0;

endmodule

### sim/tb_planar_arm_inverse_kinematics.sv
`timescale 1ns / 1ps
// self-checking testbench of the planar arm inverse kinematics solver
module tb_planar_arm_inverse_kinematics;
  import arm_ik_pkg::*;

  // generous ceiling: worst search is about 1024 tries
  localparam longint CYCLE_LIMIT = 4000000;
  localparam int     DRAIN_CYCLES = 400;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  // cordic constants of the solver, 1/65536 degree and q30
  localparam longint ROT_GAIN = 652032874;
  localparam longint Q30      = 64'sd1 << 30;
  localparam longint DEG_90   = 90 * 65536;
  localparam longint DEG_180  = 180 * 65536;
  localparam longint DEG_360  = 360 * 65536;
  localparam longint ATAN_STEP [18] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};

  typedef struct {
    logic               reachable;
    logic signed [16:0] x_used;
    logic signed [18:0] shoulder_angle;
    logic               yaw_angle;
    logic [16:0]        elbow_angle;
    logic signed [18:0] wrist_angle;
  } joint_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [16:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               action = 1'b0;
  logic signed [16:0] target_x = '0;
  logic signed [16:0] target_z = '0;
  logic signed [16:0] target_pitch = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               reachable;
  logic signed [16:0] x_used;
  logic signed [18:0] shoulder_angle;
  logic               yaw_angle;
  logic [16:0]        elbow_angle;
  logic signed [18:0] wrist_angle;

  joint_result_t pending_solutions[$];
  longint        arm_reg [7];
  int            error_count = 0;
  longint        cycle_count = 0;
  int            send_idle_pct = 0;
  int            stall_pct = 0;

  planar_arm_inverse_kinematics i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .target_x(target_x), .target_z(target_z),
    .target_pitch(target_pitch),
    .out_valid(out_valid), .out_ready(out_ready),
    .reachable(reachable), .x_used(x_used), .shoulder_angle(shoulder_angle),
    .yaw_angle(yaw_angle), .elbow_angle(elbow_angle), .wrist_angle(wrist_angle)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint sign17(longint v);
    v = v & 64'h1FFFF;
    return (v >= 65536) ? v - 131072 : v;
  endfunction

  // round half up while shifting right (floor semantics on negatives)
  function automatic longint round_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 << (s - 1))) >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // rotation cordic, angle in 1/65536 degree, result in q30
  function automatic void rotate_pitch(longint a, output longint c, output longint s);
    logic   flip;
    longint x, y, nx, ny;
    flip = 1'b0;
    x = ROT_GAIN;
    y = 0;
    while (a > DEG_180) a -= DEG_360;
    while (a < -DEG_180) a += DEG_360;
    // fold into the cordic range, negate at the end
    if (a > DEG_90) begin
      a -= DEG_180;
      flip = 1'b1;
    end else if (a < -DEG_90) begin
      a += DEG_180;
      flip = 1'b1;
    end
    for (int i = 0; i < 18; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        a -= ATAN_STEP[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        a += ATAN_STEP[i];
      end
      x = nx;
      y = ny;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // vectoring cordic arctangent after scaling the operands up to 2^40
  function automatic longint vector_angle(longint y, longint x);
    longint z, m, nx, ny, ay;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? DEG_180 : -DEG_180;
      x = -x;
      y = -y;
    end
    ay = (y < 0) ? -y : y;
    m = (x > ay) ? x : ay;
    while (m < (64'sd1 << 40)) begin
      x *= 2;
      y *= 2;
      m *= 2;
    end
    for (int i = 0; i < 18; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += ATAN_STEP[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= ATAN_STEP[i];
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  // two-link solve behind the hand link; false when out of reach
  function automatic bit solve_arm(longint x, longint z, longint pitch,
                                   output longint q1, output longint q3, output longint q4);
    longint l1, l2, l3, p, cp, sp, x2, z2, num, den, c, s, t1, t2, t3;
    l1 = arm_reg[REG_UPPER];
    l2 = arm_reg[REG_FORE];
    l3 = arm_reg[REG_HAND];
    q1 = 0;
    q3 = 0;
    q4 = 0;
    p = pitch * 256;
    rotate_pitch(p, cp, sp);
    x2 = x - round_shift(l3 * cp, 30);
    z2 = z - round_shift(l3 * sp, 30);
    num = x2 * x2 + z2 * z2 - l1 * l1 - l2 * l2;
    den = 2 * l1 * l2;
    if (den == 0 || num > den || num < -den) return 1'b0;
    c = num * Q30 / den;
    s = longint'(int_sqrt(longint'(Q30 * Q30 - c * c)));
    t2 = vector_angle(s, c);
    t1 = vector_angle(z2, x2) - vector_angle(l2 * s, l1 * Q30 + l2 * c);
    t3 = p - t1 - t2;
    q1 = round_shift(DEG_180 + t1, 8);
    q3 = round_shift(DEG_180 + t2, 8);
    q4 = round_shift(DEG_180 + t3, 8);
    return 1'b1;
  endfunction

  function automatic joint_result_t predict_joints(logic act, longint x, longint z,
                                                   longint pitch);
    joint_result_t r;
    longint q1, q3, q4, xt, zh, xu;
    bit ok;
    xu = x;
    if (!act) begin
      ok = solve_arm(x, z, pitch, q1, q3, q4);
    end else begin
      // walk x down in 1 mm steps at the raised, saturated height
      ok = 1'b0;
      xu = 0;
      xt = arm_reg[REG_X_START];
      zh = z + sign17(arm_reg[REG_Z_OFFSET]);
      if (zh > 65535) zh = 65535;
      if (zh < -65536) zh = -65536;
      while (!ok && xt > arm_reg[REG_X_STOP]) begin
        ok = solve_arm(xt, zh, sign17(arm_reg[REG_HIT_PITCH]), q1, q3, q4);
        if (ok) xu = xt;
        else xt -= 64;
      end
    end
    if (!ok) begin
      q1 = 0;
      q3 = 0;
      q4 = 0;
    end
    r.reachable      = ok;
    r.x_used         = xu[16:0];
    r.shoulder_angle = q1[18:0];
    r.yaw_angle      = 1'b0;
    r.elbow_angle    = q3[16:0];
    r.wrist_angle    = q4[18:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %0s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // one input beat; valid stays high into the next call when no gap is drawn
  task automatic send_beat(logic act, logic signed [16:0] x, logic signed [16:0] z,
                           logic signed [16:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pending_solutions.push_back(predict_joints(act, x, z, p));
    in_valid     <= 1'b1;
    action       <= act;
    target_x     <= x;
    target_z     <= z;
    target_pitch <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop valid and wait for every result; each beat gives exactly one result
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_solutions.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, longint value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[16:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < 7) arm_reg[idx] = value & ((idx >= REG_Z_OFFSET) ? 64'h1FFFF : 64'hFFFF);
  endtask

  task automatic load_arm(longint up, longint fore, longint hand, longint x0, longint x1,
                          longint zoff, longint hp);
    write_reg(REG_UPPER, up);
    write_reg(REG_FORE, fore);
    write_reg(REG_HAND, hand);
    write_reg(REG_X_START, x0);
    write_reg(REG_X_STOP, x1);
    write_reg(REG_Z_OFFSET, zoff);
    write_reg(REG_HIT_PITCH, hp);
  endtask

  // ---------------------------------------------------------------- checker

  // receiver stalls at the rate of the current phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    joint_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_solutions.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = pending_solutions.pop_front();
        if (reachable !== want.reachable)
          report_mismatch("reachable", reachable, want.reachable);
        if (x_used !== want.x_used)
          report_mismatch("x_used", x_used, want.x_used);
        if (shoulder_angle !== want.shoulder_angle)
          report_mismatch("shoulder_angle", shoulder_angle, want.shoulder_angle);
        if (yaw_angle !== want.yaw_angle)
          report_mismatch("yaw_angle", yaw_angle, want.yaw_angle);
        if (elbow_angle !== want.elbow_angle)
          report_mismatch("elbow_angle", elbow_angle, want.elbow_angle);
        if (wrist_angle !== want.wrist_angle)
          report_mismatch("wrist_angle", wrist_angle, want.wrist_angle);
      end
    end
  end

  // watchdog on a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // direct solves at reset geometry: reachable points, field extremes, wrapped pitch
  task automatic test_direct_solve();
    send_beat(1'b0, 17'sd20000, 17'sd5000, 17'sd0);
    send_beat(1'b0, 17'sd15000, -17'sd8000, 17'sd15360);
    send_beat(1'b0, -17'sd18000, 17'sd12000, -17'sd46080);
    send_beat(1'b0, 17'sd22000, 17'sd3000, 17'sd46080);
    send_beat(1'b0, 17'sd0, 17'sd0, 17'sd0);              // wrist lands near base
    send_beat(1'b0, 17'sd65535, 17'sd65535, 17'sd0);      // far out of reach
    send_beat(1'b0, -17'sd65536, -17'sd65536, -17'sd65536); // pitch outside +-180
    send_beat(1'b0, 17'sd30924, 17'sd0, 17'sd0);          // just past full stretch
    send_beat(1'b0, 17'sd10000, 17'sd0, 17'sd65535);
  endtask

  // searches at reset geometry, including z saturating at the top
  task automatic test_search();
    send_beat(1'b1, 17'sd0, 17'sd0, 17'sd0);
    send_beat(1'b1, 17'sd65535, 17'sd65535, 17'sd0);
    send_beat(1'b1, -17'sd65536, -17'sd65536, 17'sd0);
    send_beat(1'b1, 17'sd3000, 17'sd4000, 17'sd100);
  endtask

  // register extremes: zero links, empty and widest search, saturating offsets
  task automatic test_config_extremes();
    load_arm(0, 9715, 6613, 20480, 7680, 2560, 15360);
    send_beat(1'b0, 17'sd9000, 17'sd1000, 17'sd0);        // zero upper link
    write_reg(REG_UPPER, 14311);
    write_reg(REG_FORE, 0);
    send_beat(1'b1, 17'sd0, 17'sd0, 17'sd0);              // zero fore link
    load_arm(65535, 65535, 65535, 65535, 0, -65536, -46080);
    send_beat(1'b0, 17'sd65535, -17'sd65536, 17'sd46080);
    send_beat(1'b1, -17'sd65536, 17'sd0, 17'sd0);         // z lands at the low limit
    load_arm(14311, 9715, 0, 1000, 1000, 65535, 46080);
    send_beat(1'b1, 17'sd2000, 17'sd2000, 17'sd0);        // start equal to stop
    write_reg(REG_X_STOP, 65535);
    send_beat(1'b1, 17'sd2000, 17'sd2000, 17'sd0);        // start below stop
    // index past the register list must leave geometry untouched
    load_arm(14311, 9715, 6613, 20480, 7680, 2560, 15360);
    write_reg(REG_UNUSED, 17'h1ABCD);
    send_beat(1'b0, 17'sd20000, 17'sd5000, 17'sd0);
    send_beat(1'b1, 17'sd0, 17'sd0, 17'sd0);
  endtask

  // random items over four idling phases, geometry reshuffled between phases
  task automatic test_random();
    int pct_send [4] = '{0, 47, 0, 17};
    int pct_stall [4] = '{0, 0, 47, 17};
    longint up, fore, reach, x0;
    int kind;
    logic signed [16:0] rx, rz, rp;
    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      up   = $urandom_range(4000, 30000);
      fore = $urandom_range(3000, 30000);
      x0   = $urandom_range(0, 40000);
      load_arm(up, fore, $urandom_range(0, 12000), x0, x0 - $urandom_range(0, x0 < 8000 ? x0 : 8000),
               longint'($urandom_range(0, 20000)) - 10000,
               longint'($urandom_range(0, 92160)) - 46080);
      send_idle_pct = pct_send[ph];
      stall_pct     = pct_stall[ph];
      reach = up + fore;
      for (int n = 0; n < 20; n++) begin
        kind = $urandom_range(99);
        if (kind < 60) begin
          // mostly points near the workspace so the full solve path runs
          rx = 17'(longint'($urandom_range(0, 2 * reach)) - reach);
          rz = 17'(longint'($urandom_range(0, 2 * reach)) - reach);
          rp = 17'(longint'($urandom_range(0, 92160)) - 46080);
          send_beat(1'b0, rx, rz, rp);
        end else if (kind < 80) begin
          rz = 17'(longint'($urandom_range(0, 2 * reach)) - reach);
          send_beat(1'b1, 17'($urandom_range(0, 131071)), rz, 17'($urandom_range(0, 131071)));
        end else begin
          send_beat(1'($urandom_range(1)), 17'($urandom_range(0, 131071)),
                    17'($urandom_range(0, 131071)), 17'($urandom_range(0, 131071)));
        end
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 7; i++) arm_reg[i] = 0;
    arm_reg[REG_UPPER]     = CFG_RESET.l1;
    arm_reg[REG_FORE]      = CFG_RESET.l2;
    arm_reg[REG_HAND]      = CFG_RESET.l3;
    arm_reg[REG_X_START]   = CFG_RESET.x_start;
    arm_reg[REG_X_STOP]    = CFG_RESET.x_stop;
    arm_reg[REG_Z_OFFSET]  = 2560;
    arm_reg[REG_HIT_PITCH] = 15360;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_direct_solve();
    test_search();
    test_config_extremes();
    test_random();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### planar_arm_inverse_kinematics.f
src/arm_ik_pkg.sv
src/arm_ik_dp.sv
src/arm_ik_ctrl.sv
src/planar_arm_inverse_kinematics.sv
sim/tb_planar_arm_inverse_kinematics.sv
